### rtl/tgr_pkg.sv
// Shared types and constants for the touch gesture recognizer.
// Used by tgr_cfg, tgr_fsm and touch_gesture_recognizer_core; depends on nothing.
package tgr_pkg;

    // Configuration port geometry.
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_REG_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [1:0] REG_DOUBLE_TAP  = 2'd1;
    localparam logic [1:0] REG_TAP_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_SLIDE_GAP   = 2'd3;

    // Register reset values in milliseconds.
    localparam logic [CFG_REG_W-1:0] RST_LONG_PRESS  = 16'd800;
    localparam logic [CFG_REG_W-1:0] RST_DOUBLE_TAP  = 16'd300;
    localparam logic [CFG_REG_W-1:0] RST_TAP_TIMEOUT = 16'd400;
    localparam logic [CFG_REG_W-1:0] RST_SLIDE_GAP   = 16'd200;

    // Key channel codes.
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_LEFT  = 2'd1;
    localparam logic [1:0] KEY_RIGHT = 2'd2;
    localparam logic [1:0] KEY_OTHER = 2'd3;

    // Gesture codes.
    typedef enum logic [2:0] {
        G_NONE   = 3'd0,
        G_TAP    = 3'd1,
        G_LONG   = 3'd2,
        G_DOUBLE = 3'd3,
        G_SLEFT  = 3'd4,
        G_SRIGHT = 3'd5
    } t_gesture;

    // Gesture machine phases.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_WAIT  = 2'd2,
        PH_LATCH = 2'd3
    } t_phase;

    // One touch event or poll tick.
    typedef struct packed {
        logic [1:0]  key_channel;
        logic        is_down;
        logic [31:0] down_stamp;
        logic [31:0] up_stamp;
        logic [31:0] now_stamp;
    } t_in_req;

    // One gesture result.
    typedef struct packed {
        t_gesture   gesture_code;
        logic [1:0] gesture_key;
    } t_out_req;

    // Timing thresholds handed from the register file to the machine.
    typedef struct packed {
        logic [CFG_REG_W-1:0] long_press_ms;
        logic [CFG_REG_W-1:0] double_tap_ms;
        logic [CFG_REG_W-1:0] tap_timeout_ms;
        logic [CFG_REG_W-1:0] slide_gap_ms;
    } t_cfg;

endpackage

### rtl/tgr_cfg.sv
// APB-style register file holding the four gesture timing thresholds.
// Depends on tgr_pkg.
module tgr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tgr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tgr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tgr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output tgr_pkg::t_cfg                  o_cfg
);
    import tgr_pkg::*;

    logic [1:0]           reg_idx;
    logic                 wr_en;
    logic [CFG_REG_W-1:0] wr_val;
    t_cfg                 r_cfg;
    t_cfg                 n_cfg;

    // Registers sit on word boundaries; the access phase commits a write.
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign wr_val  = pwdata[CFG_REG_W-1:0];

    // Next value of the register file.
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_LONG_PRESS:  n_cfg.long_press_ms  = wr_val;
                REG_DOUBLE_TAP:  n_cfg.double_tap_ms  = wr_val;
                REG_TAP_TIMEOUT: n_cfg.tap_timeout_ms = wr_val;
                REG_SLIDE_GAP:   n_cfg.slide_gap_ms   = wr_val;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms  <= RST_LONG_PRESS;
            r_cfg.double_tap_ms  <= RST_DOUBLE_TAP;
            r_cfg.tap_timeout_ms <= RST_TAP_TIMEOUT;
            r_cfg.slide_gap_ms   <= RST_SLIDE_GAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read mux, zero-extended to the bus width.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_LONG_PRESS:  prdata[CFG_REG_W-1:0] = r_cfg.long_press_ms;
            REG_DOUBLE_TAP:  prdata[CFG_REG_W-1:0] = r_cfg.double_tap_ms;
            REG_TAP_TIMEOUT: prdata[CFG_REG_W-1:0] = r_cfg.tap_timeout_ms;
            REG_SLIDE_GAP:   prdata[CFG_REG_W-1:0] = r_cfg.slide_gap_ms;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/tgr_fsm.sv
// Gesture state machine: phase, held key and the press and release stamps,
// with the combinational decision for one event. Depends on tgr_pkg.
module tgr_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tgr_pkg::t_in_req  i_req,
    input  tgr_pkg::t_cfg     i_cfg,
    output tgr_pkg::t_out_req o_res
);
    import tgr_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [1:0]  r_held_key;
    logic [1:0]  n_held_key;
    logic [31:0] r_press_stamp;
    logic [31:0] n_press_stamp;
    logic [31:0] r_release_stamp;
    logic [31:0] n_release_stamp;

    logic [31:0] hold_time;
    logic [31:0] press_len;
    logic [31:0] idle_time;
    logic [31:0] gap;
    logic        is_long_hold;
    logic        is_long_press;
    logic        tap_expired;
    logic        is_cross;
    logic        slide_ok;
    logic        double_ok;
    logic        gap_past_double;
    t_gesture    code;
    logic [1:0]  gkey;

    // Elapsed times, all modulo 2^32.
    assign hold_time = i_req.now_stamp - r_press_stamp;
    assign press_len = i_req.up_stamp - r_press_stamp;
    assign idle_time = i_req.now_stamp - r_release_stamp;
    assign gap       = i_req.down_stamp - r_release_stamp;

    assign is_long_hold    = hold_time >= {16'd0, i_cfg.long_press_ms};
    assign is_long_press   = press_len >= {16'd0, i_cfg.long_press_ms};
    assign tap_expired     = idle_time > {16'd0, i_cfg.tap_timeout_ms};
    assign gap_past_double = gap >= {16'd0, i_cfg.double_tap_ms};

    // A slide needs a change between the left and right keys only.
    assign is_cross = ((r_held_key == KEY_LEFT) && (i_req.key_channel == KEY_RIGHT)) ||
                      ((r_held_key == KEY_RIGHT) && (i_req.key_channel == KEY_LEFT));
    assign slide_ok  = is_cross && (gap < {16'd0, i_cfg.slide_gap_ms});
    assign double_ok = !gap_past_double && (i_req.key_channel == r_held_key);

    // Next state and gesture for the event at the input register.
    always_comb begin
        n_phase         = r_phase;
        n_held_key      = r_held_key;
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        code            = G_NONE;
        gkey            = KEY_NONE;
        if (i_req.key_channel == KEY_NONE) begin
            // Poll tick: clears a latch or confirms a pending tap.
            if (r_phase == PH_LATCH) begin
                n_phase = PH_IDLE;
            end else if ((r_phase == PH_WAIT) && tap_expired) begin
                code    = G_TAP;
                gkey    = r_held_key;
                n_phase = PH_IDLE;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_req.is_down) begin
                        n_held_key    = i_req.key_channel;
                        n_press_stamp = i_req.down_stamp;
                        n_phase       = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    if (i_req.is_down) begin
                        if (is_long_hold) begin
                            code    = G_LONG;
                            gkey    = r_held_key;
                            n_phase = PH_LATCH;
                        end
                    end else begin
                        n_release_stamp = i_req.up_stamp;
                        if (is_long_press) begin
                            code    = G_LONG;
                            gkey    = r_held_key;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_WAIT;
                        end
                    end
                end
                PH_WAIT: begin
                    if (i_req.is_down) begin
                        priority if (slide_ok) begin
                            code    = (i_req.key_channel == KEY_RIGHT) ? G_SRIGHT : G_SLEFT;
                            gkey    = r_held_key;
                            n_phase = PH_LATCH;
                        end else if (double_ok) begin
                            code    = G_DOUBLE;
                            gkey    = r_held_key;
                            n_phase = PH_LATCH;
                        end else begin
                            // A late second press first reports the pending tap.
                            if (gap_past_double) begin
                                code = G_TAP;
                                gkey = r_held_key;
                            end
                            n_held_key    = i_req.key_channel;
                            n_press_stamp = i_req.down_stamp;
                            n_phase       = PH_FIRST;
                        end
                    end
                end
                PH_LATCH: begin
                    if (!i_req.is_down) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // State registers advance only when the event is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_held_key      <= KEY_NONE;
            r_press_stamp   <= '0;
            r_release_stamp <= '0;
        end else if (i_en) begin
            r_phase         <= n_phase;
            r_held_key      <= n_held_key;
            r_press_stamp   <= n_press_stamp;
            r_release_stamp <= n_release_stamp;
        end
    end

    assign o_res.gesture_code = code;
    assign o_res.gesture_key  = gkey;

    // A gesture always names a key, and no gesture names none.
    a_key_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |-> ((code == G_NONE) == (gkey == KEY_NONE)))
        else $error("gesture key does not match gesture code");

    // Double taps and slides put the machine into the latch phase.
    a_latch_after_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (code == G_DOUBLE || code == G_SLEFT || code == G_SRIGHT))
        |=> (r_phase == PH_LATCH))
        else $error("double tap or slide did not latch");

    // The held key is never empty outside idle.
    a_held_key_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_held_key != KEY_NONE))
        else $error("held key empty outside idle");

    // The press stamp and the phase stay put when no event is taken.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_en) && $past(i_rst_n) |-> $stable(r_press_stamp) && $stable(r_phase))
        else $error("state changed without an event");

endmodule

### rtl/touch_gesture_recognizer_core.sv
// Touch gesture recognizer top level: input register, gesture machine,
// result register and configuration port. Depends on tgr_pkg, tgr_cfg, tgr_fsm.
//
// The block takes one touch event or poll tick per clock while the input is not
// stalled and returns exactly one gesture result for each. A request is captured
// in the input register; the gesture machine decides tap, long press, double tap
// or slide from that register and its own state, and the answer lands in the
// result register. Sustained rate is one request per cycle while the output is
// not stalled. The input stalls only while a request is held because the result
// register is full and stalled. Thresholds are written through the APB-style
// port at byte addresses 0, 4, 8 and 12; the user must write them only while no
// request is in flight, as the block does not enforce it.
module touch_gesture_recognizer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tgr_pkg::t_in_req               i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tgr_pkg::t_out_req              o_out_req,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tgr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tgr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tgr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tgr_pkg::*;

    t_cfg     cfg;
    t_out_req res;
    logic     r_in_vld;
    logic     n_in_vld;
    t_in_req  r_in;
    logic     r_out_vld;
    logic     n_out_vld;
    t_out_req r_out;
    logic     advance;
    logic     in_take;

    // Configuration registers.
    tgr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The held request moves on when the result register is free or emptying.
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Gesture machine works on the input register.
    tgr_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Valid flags of both stages.
    always_comb begin
        n_in_vld  = in_take || (r_in_vld && !advance);
        n_out_vld = advance || (r_out_vld && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_req;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

    // The input stalls only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a stalled result");

    // Every request reaching the machine produces a result the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed request produced no result");

    // A result never overwrites one that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !advance)
        else $error("stalled result overwritten");

endmodule
